[src/pei_pkg.sv]
// pei_pkg: types, constants and tables for the pendulum euler integrator
// no dependencies; used by the channel interfaces and the top level

package pei_pkg;

  localparam int unsigned MAX_SUBSTEPS_DEF    = 4096;
  localparam int unsigned SINE_ITERATIONS_DEF = 24;

  // configuration register indexes
  localparam logic [1:0] REG_NOMINAL_STEP   = 2'd0;
  localparam logic [1:0] REG_GRAVITY_LENGTH = 2'd1;
  localparam logic [1:0] REG_INV_INERTIA    = 2'd2;

  localparam logic [31:0] NOMINAL_STEP_RST   = 32'd1073742;
  localparam logic [31:0] GRAVITY_LENGTH_RST = 32'd54861496;
  localparam logic [31:0] INV_INERTIA_RST    = 32'd932068;

  // angle constants in q.30
  localparam logic signed [36:0] PI_Q30      = 37'sd3373259426;
  localparam logic signed [36:0] TWO_PI_Q30  = 37'sd6746518852;
  localparam logic signed [36:0] HALF_PI_Q30 = 37'sd1686629713;
  localparam logic [31:0]        ONE_Q30     = 32'h4000_0000;

  typedef struct packed {
    logic signed [31:0] start_angle;
    logic signed [31:0] start_rate;
    logic signed [31:0] torque;
    logic [31:0]        duration;
  } pei_in_t;

  typedef struct packed {
    logic signed [31:0] end_angle;
    logic signed [31:0] end_rate;
    logic               overflow;
  } pei_out_t;

  // series divisor 2k(2k+1)
  function automatic logic [12:0] sine_div(input logic [5:0] k);
    logic [13:0] k2;
    k2 = {7'd0, k, 1'b0};
    return 13'(k2 * (k2 + 14'd1));
  endfunction

  // floor(2^32 / (2k(2k+1)))
  function automatic logic [29:0] sine_recip(input logic [5:0] k);
    logic [29:0] r;
    case (k)
      6'd1:    r = 30'd715827882;
      6'd2:    r = 30'd214748364;
      6'd3:    r = 30'd102261126;
      6'd4:    r = 30'd59652323;
      6'd5:    r = 30'd39045157;
      6'd6:    r = 30'd27531841;
      6'd7:    r = 30'd20452225;
      6'd8:    r = 30'd15790320;
      6'd9:    r = 30'd12558383;
      6'd10:   r = 30'd10226112;
      6'd11:   r = 30'd8488077;
      6'd12:   r = 30'd7158278;
      6'd13:   r = 30'd6118187;
      6'd14:   r = 30'd5289368;
      6'd15:   r = 30'd4618244;
      6'd16:   r = 30'd4067203;
      6'd17:   r = 30'd3609216;
      6'd18:   r = 30'd3224449;
      6'd19:   r = 30'd2898088;
      6'd20:   r = 30'd2618882;
      6'd21:   r = 30'd2378165;
      6'd22:   r = 30'd2169175;
      6'd23:   r = 30'd1986571;
      6'd24:   r = 30'd1826091;
      6'd25:   r = 30'd1684300;
      6'd26:   r = 30'd1558406;
      6'd27:   r = 30'd1446116;
      6'd28:   r = 30'd1345541;
      6'd29:   r = 30'd1255104;
      6'd30:   r = 30'd1173488;
      6'd31:   r = 30'd1099582;
      6'd32:   r = 30'd1032444;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

[src/pei_in_if.sv]
// pei_in_if: input item channel, valid/ready with pei_pkg::pei_in_t payload
// depends on pei_pkg

interface pei_in_if;
  import pei_pkg::*;
  logic    valid;
  logic    ready;
  pei_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/pei_out_if.sv]
// pei_out_if: result item channel, valid/ready with pei_pkg::pei_out_t payload
// depends on pei_pkg

interface pei_out_if;
  import pei_pkg::*;
  logic     valid;
  logic     ready;
  pei_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/pendulum_euler_integrator.sv]
// pendulum_euler_integrator: symplectic euler pendulum step on a shared 33x33 multiplier
// sequence: two divisions (substep count, step length), torque scaling, then per substep
//   the angle update, angle reduction, sine recurrence and rate update; with zero
//   substeps the result follows the first division
// throughput: one item at a time, set by the shared multiplier and the sine recurrence
// a result waits in the output register; the next item is taken meanwhile
// reset: rst_ni asynchronous active low, clears control state and loads register defaults

module pendulum_euler_integrator #(
  parameter int unsigned MAX_SUBSTEPS    = pei_pkg::MAX_SUBSTEPS_DEF,
  parameter int unsigned SINE_ITERATIONS = pei_pkg::SINE_ITERATIONS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  pei_in_if.sink      in_if,
  pei_out_if.source   out_if
);
  import pei_pkg::*;

  localparam int unsigned NW = $clog2(MAX_SUBSTEPS + 1);
  localparam int unsigned KW = $clog2(SINE_ITERATIONS + 1);

  typedef enum logic [20:0] {
    S_IDLE = 21'h000001,
    S_DIV  = 21'h000002,
    S_TQ   = 21'h000004,
    S_TQW  = 21'h000008,
    S_ANG  = 21'h000010,
    S_ANGS = 21'h000020,
    S_RED  = 21'h000040,
    S_FOLD = 21'h000080,
    S_SQ   = 21'h000100,
    S_X2   = 21'h000200,
    S_IA   = 21'h000400,
    S_IB   = 21'h000800,
    S_IC   = 21'h001000,
    S_ID   = 21'h002000,
    S_SN   = 21'h004000,
    S_SG   = 21'h008000,
    S_AC   = 21'h010000,
    S_SL   = 21'h020000,
    S_SH   = 21'h040000,
    S_RT   = 21'h080000,
    S_FIN  = 21'h100000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [31:0] nom_step_q, grav_q, inv_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nom_step_q <= NOMINAL_STEP_RST;
      grav_q     <= GRAVITY_LENGTH_RST;
      inv_in_q   <= INV_INERTIA_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NOMINAL_STEP:   nom_step_q <= cfg_data_i;
        REG_GRAVITY_LENGTH: grav_q     <= cfg_data_i;
        REG_INV_INERTIA:    inv_in_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // working registers (payload, no reset)
  logic signed [31:0] angle_q, angle_d, rate_q, rate_d, torque_q, torque_d;
  logic [31:0]        dur_q, dur_d;
  logic [31:0]        dt_q, dt_d;
  logic signed [39:0] tq_q, tq_d;
  logic signed [36:0] x_q, x_d;
  logic signed [31:0] xs_q, xs_d;
  logic [31:0]        x2_q, x2_d;
  logic [30:0]        s_q, s_d;
  logic [31:0]        p_q, p_d;
  logic [31:0]        qe_q, qe_d;
  logic signed [40:0] acc_q, acc_d;
  logic [47:0]        plo_q, plo_d;
  logic signed [65:0] prod_q;

  // control registers
  logic [NW-1:0] n_q, n_d;
  logic [KW-1:0] k_q, k_d;
  logic          ovf_q, ovf_d;
  logic [31:0]   quo_q, quo_d, rem_q, rem_d, dsr_q, dsr_d;
  logic [4:0]    dcnt_q, dcnt_d;
  logic          dph_q, dph_d;
  logic          out_valid_q, out_valid_d;
  pei_out_t      out_q, out_d;

  // shared multiplier operands
  logic signed [32:0] mul_a, mul_b;

  // divider step
  logic [32:0] rem_sh;
  logic        div_ge;
  logic [31:0] quo_nx;

  // misc datapath
  logic signed [34:0] ang_sum;
  logic signed [36:0] fold_y, fold_r;
  logic [31:0]        rem_c, q_c;
  logic [12:0]        d_k;
  logic [29:0]        r_k;
  logic signed [40:0] acc_c;
  logic signed [73:0] dsum;
  logic signed [42:0] rate_sum;

  assign d_k = sine_div(6'(k_q));
  assign r_k = sine_recip(6'(k_q));

  assign rem_sh = {rem_q, quo_q[31]};
  assign div_ge = rem_sh >= {1'b0, dsr_q};
  assign quo_nx = {quo_q[30:0], div_ge};

  assign ang_sum  = 35'(angle_q) + 35'(signed'(prod_q[65:32]));
  assign fold_y   = (x_q > PI_Q30) ? x_q - TWO_PI_Q30 : x_q;
  assign fold_r   = (fold_y > HALF_PI_Q30) ? PI_Q30 - fold_y :
                    (fold_y < -HALF_PI_Q30) ? -PI_Q30 - fold_y : fold_y;
  assign rem_c    = p_q - prod_q[31:0];
  assign q_c      = qe_q + {31'd0, (rem_c >= {19'd0, d_k})};
  assign acc_c    = 41'(signed'(prod_q[65:28])) + 41'(tq_q);
  assign dsum     = {prod_q[57:0], 16'd0} + {26'd0, plo_q};
  assign rate_sum = 43'(rate_q) + 43'(signed'(dsum[73:32]));

  assign in_if.ready  = (state_q == S_IDLE);
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  always_comb begin
    state_d     = state_q;
    angle_d     = angle_q;
    rate_d      = rate_q;
    torque_d    = torque_q;
    dur_d       = dur_q;
    dt_d        = dt_q;
    tq_d        = tq_q;
    x_d         = x_q;
    xs_d        = xs_q;
    x2_d        = x2_q;
    s_d         = s_q;
    p_d         = p_q;
    qe_d        = qe_q;
    acc_d       = acc_q;
    plo_d       = plo_q;
    n_d         = n_q;
    k_d         = k_q;
    ovf_d       = ovf_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    dsr_d       = dsr_q;
    dcnt_d      = dcnt_q;
    dph_d       = dph_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mul_a       = '0;
    mul_b       = '0;

    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          angle_d  = in_if.data.start_angle;
          rate_d   = in_if.data.start_rate;
          torque_d = in_if.data.torque;
          dur_d    = in_if.data.duration;
          ovf_d    = 1'b0;
          // substep count = duration / nominal step, zero step taken as one
          quo_d    = in_if.data.duration;
          rem_d    = '0;
          dsr_d    = (nom_step_q == 32'd0) ? 32'd1 : nom_step_q;
          dcnt_d   = '0;
          dph_d    = 1'b0;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        // restoring divider, one quotient bit a cycle
        rem_d  = div_ge ? 32'(rem_sh - {1'b0, dsr_q}) : rem_sh[31:0];
        quo_d  = quo_nx;
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd31) begin
          if (!dph_q) begin
            if (quo_nx == 32'd0) begin
              // no substeps: start state goes out unchanged
              state_d = S_FIN;
            end else begin
              if (quo_nx > 32'(MAX_SUBSTEPS)) begin
                n_d   = NW'(MAX_SUBSTEPS);
                ovf_d = 1'b1;
                dsr_d = 32'(MAX_SUBSTEPS);
              end else begin
                n_d   = NW'(quo_nx);
                dsr_d = quo_nx;
              end
              quo_d  = dur_q;
              rem_d  = '0;
              dcnt_d = '0;
              dph_d  = 1'b1;
            end
          end else begin
            dt_d    = quo_nx;
            state_d = S_TQ;
          end
        end
      end
      S_TQ: begin
        mul_a   = 33'(torque_q);
        mul_b   = {1'b0, inv_in_q};
        state_d = S_TQW;
      end
      S_TQW: begin
        tq_d    = prod_q[63:24];
        state_d = S_ANG;
      end
      S_ANG: begin
        mul_a   = {1'b0, dt_q};
        mul_b   = 33'(rate_q);
        state_d = S_ANGS;
      end
      S_ANGS: begin
        // angle update, saturated, then angle times 16 into q.30
        if (ang_sum > 35'sd2147483647) begin
          angle_d = 32'sh7fff_ffff;
          ovf_d   = 1'b1;
        end else if (ang_sum < -35'sd2147483648) begin
          angle_d = 32'sh8000_0000;
          ovf_d   = 1'b1;
        end else begin
          angle_d = ang_sum[31:0];
        end
        x_d     = {angle_d[31], angle_d, 4'd0};
        state_d = S_RED;
      end
      S_RED: begin
        // bring the angle into [0, 2pi)
        if (x_q < 37'sd0) begin
          x_d = x_q + TWO_PI_Q30;
        end else if (x_q >= TWO_PI_Q30) begin
          x_d = x_q - TWO_PI_Q30;
        end else begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        // to (-pi, pi], then reflect into [-pi/2, pi/2]
        xs_d    = fold_r[31:0];
        state_d = S_SQ;
      end
      S_SQ: begin
        mul_a   = 33'(xs_q);
        mul_b   = 33'(xs_q);
        state_d = S_X2;
      end
      S_X2: begin
        x2_d    = prod_q[61:30];
        s_d     = 31'(ONE_Q30);
        k_d     = KW'(SINE_ITERATIONS);
        state_d = S_IA;
      end
      S_IA: begin
        mul_a   = {1'b0, x2_q};
        mul_b   = {2'b0, s_q};
        state_d = S_IB;
      end
      S_IB: begin
        // p = x2*s in q.30, times reciprocal of the series divisor
        p_d     = prod_q[61:30];
        mul_a   = {1'b0, prod_q[61:30]};
        mul_b   = {3'b0, r_k};
        state_d = S_IC;
      end
      S_IC: begin
        qe_d    = prod_q[63:32];
        mul_a   = {1'b0, prod_q[63:32]};
        mul_b   = {20'b0, d_k};
        state_d = S_ID;
      end
      S_ID: begin
        // quotient estimate is exact or one low
        s_d = 31'(ONE_Q30 - q_c);
        if (k_q == KW'(1)) begin
          state_d = S_SN;
        end else begin
          k_d     = k_q - KW'(1);
          state_d = S_IA;
        end
      end
      S_SN: begin
        mul_a   = 33'(xs_q);
        mul_b   = {2'b0, s_q};
        state_d = S_SG;
      end
      S_SG: begin
        mul_a   = 33'(signed'(prod_q[61:30]));
        mul_b   = {1'b0, grav_q};
        state_d = S_AC;
      end
      S_AC: begin
        acc_d   = acc_c;
        state_d = S_SL;
      end
      S_SL: begin
        // dt*acc split into low 16 bits and high part
        mul_a   = {1'b0, dt_q};
        mul_b   = {17'b0, acc_q[15:0]};
        state_d = S_SH;
      end
      S_SH: begin
        plo_d   = prod_q[47:0];
        mul_a   = {1'b0, dt_q};
        mul_b   = 33'(signed'(acc_q[40:16]));
        state_d = S_RT;
      end
      S_RT: begin
        if (rate_sum > 43'sd2147483647) begin
          rate_d = 32'sh7fff_ffff;
          ovf_d  = 1'b1;
        end else if (rate_sum < -43'sd2147483648) begin
          rate_d = 32'sh8000_0000;
          ovf_d  = 1'b1;
        end else begin
          rate_d = rate_sum[31:0];
        end
        if (n_q == NW'(1)) begin
          state_d = S_FIN;
        end else begin
          n_d     = n_q - NW'(1);
          state_d = S_ANG;
        end
      end
      S_FIN: begin
        // wait for the output register to free up
        if (!out_valid_q || out_if.ready) begin
          out_d.end_angle = angle_q;
          out_d.end_rate  = rate_q;
          out_d.overflow  = ovf_q;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      k_q         <= '0;
      ovf_q       <= 1'b0;
      dcnt_q      <= '0;
      dph_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      k_q         <= k_d;
      ovf_q       <= ovf_d;
      dcnt_q      <= dcnt_d;
      dph_q       <= dph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q  <= angle_d;
    rate_q   <= rate_d;
    torque_q <= torque_d;
    dur_q    <= dur_d;
    dt_q     <= dt_d;
    tq_q     <= tq_d;
    x_q      <= x_d;
    xs_q     <= xs_d;
    x2_q     <= x2_d;
    s_q      <= s_d;
    p_q      <= p_d;
    qe_q     <= qe_d;
    acc_q    <= acc_d;
    plo_q    <= plo_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    dsr_q    <= dsr_d;
    out_q    <= out_d;
    prod_q   <= mul_a * mul_b;
  end

endmodule

[sim/pendulum_euler_integrator_tb.sv]
// pendulum_euler_integrator_tb: self-checking bench for the pendulum step integrator
// depends on pei_pkg, pei_in_if, pei_out_if and the pendulum_euler_integrator rtl
// a local fixed-point predictor checks every result item, mostly under random idling on both sides

module pendulum_euler_integrator_tb;
  import pei_pkg::*;

  localparam int unsigned RUN_LIMIT = 20_000_000;  // cycles
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam logic [1:0] REG_UNUSED = 2'd3;       // no register behind this index

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  pei_in_if  in_ch ();
  pei_out_if out_ch ();

  pendulum_euler_integrator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  // local copy of the configuration registers
  logic [31:0] step_reg;
  logic [31:0] grav_reg;
  logic [31:0] inertia_reg;

  pei_in_t  swing_queue[$];   // items waiting to be driven
  pei_out_t swing_expect[$];  // predicted result items, oldest first
  int       send_idle_pct;
  int       recv_idle_pct;
  bit       hold_send;        // sender holds off until all results are back
  int       fail_count;
  int unsigned cycle_count;

  // clock; the single reset is applied by the test sequence
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // saturate to 32 bit signed, flag clipping
  function automatic longint clip32(input longint v, inout bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // floor(dt * a / 2^32), formed wide so nothing wraps
  function automatic longint scale_by_dt(input logic [31:0] dt, input longint a);
    logic signed [127:0] wa;
    logic signed [127:0] wd;
    logic signed [127:0] prod;
    wa = a;
    wd = $signed({96'd0, dt});
    prod = wa * wd;
    return longint'(prod >>> 32);
  endfunction

  // sine of a q6.26 angle, q.30 result, truncated series in horner form
  function automatic longint sine_q30_of(input longint ang);
    longint two_pi;
    longint pi;
    longint half_pi;
    longint x;
    longint x2;
    longint s;
    longint d;
    two_pi = longint'(TWO_PI_Q30);
    pi = longint'(PI_Q30);
    half_pi = longint'(HALF_PI_Q30);
    x = (ang * 16) % two_pi;  // truncating remainder
    if (x < 0) x += two_pi;
    if (x > pi) x -= two_pi;
    // fold into [-pi/2, pi/2]
    if (x > half_pi) x = pi - x;
    else if (x < -half_pi) x = -pi - x;
    x2 = (x * x) >>> 30;
    s = 64'sd1 << 30;
    for (int k = SINE_ITERATIONS_DEF; k >= 1; k--) begin
      d = longint'(2 * k) * longint'(2 * k + 1);
      s = (64'sd1 << 30) - (((x2 * s) >>> 30) / d);  // division truncates toward zero
    end
    return (x * s) >>> 30;
  endfunction

  function automatic pei_out_t predict_swing(input pei_in_t it);
    pei_out_t    res;
    longint      angle;
    longint      rate;
    longint      tq;
    longint      acc;
    logic [31:0] stp;
    logic [31:0] dt;
    longint unsigned n;
    bit          ovf;
    angle = longint'(it.start_angle);
    rate = longint'(it.start_rate);
    ovf = 1'b0;
    stp = (step_reg == 32'd0) ? 32'd1 : step_reg;  // zero step acts as one
    n = longint'({32'd0, it.duration / stp});
    // too many substeps: clamp and flag
    if (n > MAX_SUBSTEPS_DEF) begin
      n = MAX_SUBSTEPS_DEF;
      ovf = 1'b1;
    end
    if (n > 0) begin
      dt = 32'(longint'({32'd0, it.duration}) / n);
      tq = (longint'(it.torque) * longint'({32'd0, inertia_reg})) >>> 24;
      for (longint unsigned i = 0; i < n; i++) begin
        angle = clip32(angle + scale_by_dt(dt, rate), ovf);
        acc = ((sine_q30_of(angle) * longint'({32'd0, grav_reg})) >>> 28) + tq;
        rate = clip32(rate + scale_by_dt(dt, acc), ovf);
      end
    end
    res.end_angle = angle[31:0];
    res.end_rate = rate[31:0];
    res.overflow = ovf;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: feeds items from the queue, predicts at acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        swing_expect.push_back(predict_swing(in_ch.data));
      end
      if (!in_ch.valid || in_ch.ready) begin
        // slot free: offer the next item unless idling or held
        if (swing_queue.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= swing_queue.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure, compares each result item to the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (swing_expect.size() == 0) begin
          $error("result item with no prediction waiting");
          fail_count++;
        end else begin
          pei_out_t want;
          want = swing_expect.pop_front();
          if (out_ch.data.end_angle !== want.end_angle) begin
            $error("end_angle: expected %0d, actual %0d", want.end_angle,
                   out_ch.data.end_angle);
            fail_count++;
          end
          if (out_ch.data.end_rate !== want.end_rate) begin
            $error("end_rate: expected %0d, actual %0d", want.end_rate,
                   out_ch.data.end_rate);
            fail_count++;
          end
          if (out_ch.data.overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow,
                   out_ch.data.overflow);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("pendulum_euler_integrator regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one register write per edge; caller drops the enable after a batch
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_NOMINAL_STEP:   step_reg = val;
      REG_GRAVITY_LENGTH: grav_reg = val;
      REG_INV_INERTIA:    inertia_reg = val;
      default: ;  // unknown index, ignored by the block
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // block goes idle: every item sent, every result back, then settle time
  // checked at the falling edge so the driver's updates have landed
  task automatic wait_drained();
    while (swing_queue.size() != 0 || in_ch.valid || swing_expect.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_item(input logic [31:0] ang, input logic [31:0] rt,
                           input logic [31:0] tqv, input logic [31:0] dur);
    pei_in_t it;
    it.start_angle = ang;
    it.start_rate = rt;
    it.torque = tqv;
    it.duration = dur;
    swing_queue.push_back(it);
  endtask

  // random item; durations give a few substeps so the run stays short
  task automatic push_random(input int cnt);
    logic [31:0]     stp;
    longint unsigned n_max;
    longint unsigned n;
    longint unsigned dur;
    logic [31:0]     ang;
    logic [31:0]     rt;
    stp = (step_reg == 32'd0) ? 32'd1 : step_reg;
    n_max = 64'hFFFF_FFFF / stp;
    if (n_max > 12) n_max = 12;
    for (int i = 0; i < cnt; i++) begin
      n = $urandom_range(int'(n_max));
      dur = n * stp + ($urandom % stp);
      if (dur > 64'hFFFF_FFFF) dur = n * stp;
      // half the items keep angle and rate moderate so they stay unsaturated
      ang = $urandom;
      rt = $urandom;
      if ($urandom_range(1)) begin
        ang = {{5{ang[31]}}, ang[26:0]};
        rt = {{6{rt[31]}}, rt[25:0]};
      end
      push_item(ang, rt, $urandom, dur[31:0]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_NOMINAL_STEP;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cycle_count = 0;
    fail_count = 0;
    hold_send = 1'b0;
    send_idle_pct = 21;
    recv_idle_pct = 78;
    step_reg = NOMINAL_STEP_RST;
    grav_reg = GRAVITY_LENGTH_RST;
    inertia_reg = INV_INERTIA_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration, directed corners
    push_item(32'd0, 32'd0, 32'd0, 32'd0);                      // zero substeps
    push_item(32'h1234_5678, 32'hF000_0000, 32'd0, 32'd1073741); // just below one step
    push_item(32'h0400_0000, 32'd0, 32'd0, 32'd1073742);         // exactly one step
    push_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd3221226); // saturate up
    push_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd3221226); // saturate down
    push_item(32'h0C90_FDAA, 32'd0, 32'h7FFF_FFFF, 32'd5368710); // near pi, torque max
    push_item(32'hF36F_0256, 32'd0, 32'h8000_0000, 32'd5368710); // near -pi, torque min
    push_item(32'h0648_7ED5, 32'h0400_0000, 32'd0, 32'd21474840); // near pi/2, 20 steps
    push_random(10);
    wait_drained();

    // zero step acts as one; unknown register index is ignored
    write_reg(REG_NOMINAL_STEP, 32'd0);
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    end_writes();
    push_item(32'h0200_0000, 32'hFE00_0000, 32'h0100_0000, 32'd3);
    push_item(32'h0100_0000, 32'h0100_0000, 32'd0, 32'd5000);     // clamped substeps
    push_item(32'hFF00_0000, 32'h0000_1000, 32'd7, 32'hFFFF_FFFF); // clamped, longest dt
    push_random(6);
    wait_drained();

    // coarse step, random coefficients; the sender pauses once midway
    write_reg(REG_NOMINAL_STEP, 32'h1000_0000);
    write_reg(REG_GRAVITY_LENGTH, $urandom);
    write_reg(REG_INV_INERTIA, $urandom);
    end_writes();
    push_random(20);
    while (swing_queue.size() != 0) @(posedge clk_i);
    hold_send = 1'b1;
    while (in_ch.valid || swing_expect.size() != 0) @(negedge clk_i);
    hold_send = 1'b0;
    push_random(25);
    wait_drained();

    // largest register values, two extreme items, idling swapped
    send_idle_pct = 78;
    recv_idle_pct = 21;
    write_reg(REG_NOMINAL_STEP, 32'hFFFF_FFFF);
    write_reg(REG_GRAVITY_LENGTH, 32'hFFFF_FFFF);
    write_reg(REG_INV_INERTIA, 32'hFFFF_FFFF);
    end_writes();
    push_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_item(32'h0000_0001, 32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF);
    push_random(30);
    wait_drained();

    // reset step, zero coefficients: free rotation; no idling at all
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_NOMINAL_STEP, NOMINAL_STEP_RST);
    write_reg(REG_GRAVITY_LENGTH, 32'd0);
    write_reg(REG_INV_INERTIA, 32'd0);
    end_writes();
    push_random(20);
    wait_drained();

    // small step, mid coefficients
    write_reg(REG_NOMINAL_STEP, 32'd4_000_000);
    write_reg(REG_GRAVITY_LENGTH, GRAVITY_LENGTH_RST);
    write_reg(REG_INV_INERTIA, 32'h0100_0000);
    end_writes();
    push_random(30);
    wait_drained();

    if (fail_count == 0) begin
      $display("pendulum_euler_integrator regression: pass");
    end else begin
      $display("pendulum_euler_integrator regression: fail");
    end
    $finish;
  end

endmodule

[pendulum_euler_integrator.f]
src/pei_pkg.sv
src/pei_in_if.sv
src/pei_out_if.sv
src/pendulum_euler_integrator.sv
sim/pendulum_euler_integrator_tb.sv
